[src/assert_macros.svh]
// Assertion macros used by the top-level RTL file of the pose step block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("same-cycle check failed");
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("next-cycle check failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, a, c)
`define ASSERT_NEXT(lbl, clk, rst_n, a, c)
`endif
`endif

[src/ddps_pkg.sv]
// Package: shared widths, constants, register indexes and the arctangent table
package ddps_pkg;

	localparam int CORDIC_STEPS_DEF      = 16;
	localparam int HEADING_FRAC_BITS_DEF = 16;

	localparam int MUL_A_W = 24;
	localparam int MUL_B_W = 18;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int DEN_W   = 34;
	localparam int TRIG_W  = 33;

	localparam logic [13:0] TWO_PI_Q11 = 14'd12868;
	localparam logic signed [TRIG_W-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;

	localparam logic [3:0] REG_ACCEL_RATE   = 4'd0;
	localparam logic [3:0] REG_SPEED_LIMIT  = 4'd1;
	localparam logic [3:0] REG_FRICTION     = 4'd2;
	localparam logic [3:0] REG_DEADBAND     = 4'd3;
	localparam logic [3:0] REG_TRACK_WIDTH  = 4'd4;
	localparam logic [3:0] REG_BOUND_LOW    = 4'd5;
	localparam logic [3:0] REG_BOUND_HIGH_X = 4'd6;
	localparam logic [3:0] REG_BOUND_HIGH_Y = 4'd7;

	// arctan(2^-i) as a 32-bit binary angle
	function automatic logic [31:0] atan_entry(input logic [4:0] idx);
		logic [31:0] v;
		unique case (idx)
			5'd0:  v = 32'h20000000;
			5'd1:  v = 32'h12E4051E;
			5'd2:  v = 32'h09FB385B;
			5'd3:  v = 32'h051111D4;
			5'd4:  v = 32'h028B0D43;
			5'd5:  v = 32'h0145D7E1;
			5'd6:  v = 32'h00A2F61E;
			5'd7:  v = 32'h00517C55;
			5'd8:  v = 32'h0028BE53;
			5'd9:  v = 32'h00145F2F;
			5'd10: v = 32'h000A2F98;
			5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6;
			5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2F9;
			5'd15: v = 32'h0000517C;
			5'd16: v = 32'h000028BE;
			5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A2F;
			5'd19: v = 32'h00000517;
			5'd20: v = 32'h0000028B;
			5'd21: v = 32'h00000145;
			5'd22: v = 32'h000000A2;
			5'd23: v = 32'h00000051;
			default: v = 32'h0;
		endcase
		return v;
	endfunction

endpackage

[src/differential_drive_pose_step.sv]
// Top level: pose step sequencer around a shared multiplier, divider and CORDIC
//
// One input transaction is one time tick: four command bits and time_step.
// The block applies the commands, friction, deadband and speed clamp to both
// wheels, turns the heading, rotates with a CORDIC and moves x and y, then
// offers exactly one result transaction carrying pose and wheel speeds.
// Channels use valid/ready; in_ready is high only while the sequencer idles.
// The next tick is accepted only after the sequencer has finished the last
// one and loaded its result into the output register; that time is set by
// the bit-serial heading divider and by the CORDIC_STEPS rotations.
// The result sits in an output register, so the next tick may be accepted
// while it waits; if the receiver still stalls when the next result is ready
// the sequencer holds in its final state until the register frees.
// Configuration writes take effect at once and should happen while idle;
// indexes beyond the register list are ignored.
// Reset (arst_n low) zeroes the wheel speeds and heading, puts x and y at
// 150 cm and restores the register defaults.
`include "assert_macros.svh"
module differential_drive_pose_step #(
	parameter int CORDIC_STEPS      = ddps_pkg::CORDIC_STEPS_DEF,
	parameter int HEADING_FRAC_BITS = ddps_pkg::HEADING_FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [3:0]         cfg_index,
	input  logic [19:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               spin_positive,
	input  logic               spin_negative,
	input  logic               left_reverse,
	input  logic               right_reverse,
	input  logic [15:0]        time_step,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [19:0]        pos_x,
	output logic [19:0]        pos_y,
	output logic [15:0]        heading,
	output logic signed [18:0] left_speed,
	output logic signed [18:0] right_speed
);

	localparam int ACC_W = 16 + HEADING_FRAC_BITS;
	localparam int NUM_W = 47 + HEADING_FRAC_BITS;
	localparam int SHIFT = HEADING_FRAC_BITS + 11;
	localparam int TW    = ddps_pkg::TRIG_W;

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_MACC = 5'd1;
	localparam logic [4:0] S_CMD  = 5'd2;
	localparam logic [4:0] S_MFL  = 5'd3;
	localparam logic [4:0] S_MFR  = 5'd4;
	localparam logic [4:0] S_RSH  = 5'd5;
	localparam logic [4:0] S_MDIF = 5'd6;
	localparam logic [4:0] S_MDEN = 5'd7;
	localparam logic [4:0] S_MSUM = 5'd8;
	localparam logic [4:0] S_WP   = 5'd9;
	localparam logic [4:0] S_DIV  = 5'd10;
	localparam logic [4:0] S_HUPD = 5'd11;
	localparam logic [4:0] S_CORD = 5'd12;
	localparam logic [4:0] S_TSL  = 5'd13;
	localparam logic [4:0] S_TSH  = 5'd14;
	localparam logic [4:0] S_TCL  = 5'd15;
	localparam logic [4:0] S_TCH  = 5'd16;
	localparam logic [4:0] S_TY   = 5'd17;
	localparam logic [4:0] S_DONE = 5'd18;

	// configuration registers
	logic [17:0] accel_q, lim_q;
	logic [15:0] ff_q, db_q;
	logic [19:0] tw_q, blo_q, bhx_q, bhy_q;

	// sequencer and working state
	logic [4:0]         state_q;
	logic [3:0]         cmd_q;
	logic [15:0]        dt_q;
	logic signed [21:0] lw_q, rw_q;
	logic signed [18:0] l_q, r_q;
	logic [19:0]        x_q, y_q;
	logic [ACC_W-1:0]   acc_q;
	logic               diffneg_q, psign_q;
	logic [34:0]        prod_q, pmag_q;
	logic [35:0]        plo_q;
	logic               out_valid_q;

	logic [ddps_pkg::MUL_A_W-1:0] mul_a;
	logic [ddps_pkg::MUL_B_W-1:0] mul_b;
	logic [ddps_pkg::MUL_P_W-1:0] mul_p;

	logic                 div_start, div_done;
	logic [NUM_W-1:0]     div_dividend;
	logic [ACC_W-1:0]     div_quot;
	logic                 cor_start, cor_done;
	logic signed [TW-1:0] cos_v, sin_v;
	logic [ACC_W-1:0]     acc_nx;

	logic               accept, out_free;
	logic [34:0]        d_sum;
	logic signed [21:0] dd, cl, cr;
	logic [37:0]        fr_sum;
	logic [21:0]        fr_mag;
	logic [17:0]        sh_mag;
	logic               sh_neg;
	logic signed [18:0] sh_val;
	logic signed [19:0] diff, psum;
	logic [19:0]        diff_mag, psum_mag;
	logic [19:0]        tw_eff;
	logic signed [TW-1:0] trig;
	logic [TW-1:0]      trig_mag;
	logic [TW:0]        t_sum;
	logic [17:0]        t16;
	logic [54:0]        mv_sum;
	logic [21:0]        mv_m;
	logic               mv_sub;
	logic signed [23:0] pos_old, pos_new, pos_lo, pos_hi, pos_cl;

	assign accept   = in_valid && in_ready;
	assign in_ready = state_q == S_IDLE;
	assign out_free = !out_valid_q || out_ready;

	// apply the command bits with d = round(accel * dt)
	always_comb begin
		d_sum = {1'b0, mul_p[33:0]} + 35'h8000;
		dd    = $signed({3'b0, d_sum[34:16]});
		cl    = 22'(l_q);
		cr    = 22'(r_q);
		if (cmd_q[0]) begin
			cl = cl - dd;
			cr = cr + dd;
		end
		if (cmd_q[1]) begin
			cl = cl + dd;
			cr = cr - dd;
		end
		if (cmd_q[2]) begin
			cl = cl - dd;
		end
		if (cmd_q[3]) begin
			cr = cr - dd;
		end
	end

	// friction rounding, deadband and magnitude clamp for one wheel
	always_comb begin
		fr_sum = mul_p[37:0] + 38'h8000;
		fr_mag = fr_sum[37:16];
		sh_neg = (state_q == S_MFR) ? lw_q[21] : rw_q[21];
		if (fr_mag < {6'b0, db_q}) begin
			sh_mag = '0;
		end else if (fr_mag > {4'b0, lim_q}) begin
			sh_mag = lim_q;
		end else begin
			sh_mag = fr_mag[17:0];
		end
		sh_val = sh_neg ? -$signed({1'b0, sh_mag}) : $signed({1'b0, sh_mag});
	end

	// speed sum and difference, heading dividend
	always_comb begin
		diff         = 20'(r_q) - 20'(l_q);
		psum         = 20'(r_q) + 20'(l_q);
		diff_mag     = diff[19] ? 20'(-diff) : 20'(diff);
		psum_mag     = psum[19] ? 20'(-psum) : 20'(psum);
		tw_eff       = (tw_q == '0) ? 20'd1 : tw_q;
		div_dividend = (NUM_W'(prod_q) << SHIFT) + NUM_W'(mul_p[33:1]);
		acc_nx       = diffneg_q ? acc_q - div_quot : acc_q + div_quot;
	end

	// trig rounded to Q16 and the two-part move product
	always_comb begin
		trig     = (state_q == S_TSL || state_q == S_TSH) ? sin_v : cos_v;
		trig_mag = trig[TW-1] ? TW'(-trig) : TW'(trig);
		t_sum    = {1'b0, trig_mag} + (TW+1)'(14'h2000);
		t16      = t_sum[31:14];
		mv_sum   = {1'b0, mul_p[35:0], 18'b0} + 55'(plo_q) + (55'd1 << 32);
		mv_m     = mv_sum[54:33];
	end

	// add or subtract the move and clamp the coordinate
	always_comb begin
		if (state_q == S_TCL) begin
			pos_old = $signed({4'b0, x_q});
			pos_hi  = $signed({4'b0, bhx_q});
			mv_sub  = sin_v[TW-1] ^ psign_q;
		end else begin
			pos_old = $signed({4'b0, y_q});
			pos_hi  = $signed({4'b0, bhy_q});
			mv_sub  = !(cos_v[TW-1] ^ psign_q);
		end
		pos_lo  = $signed({4'b0, blo_q});
		pos_new = mv_sub ? pos_old - $signed({2'b0, mv_m}) : pos_old + $signed({2'b0, mv_m});
		pos_cl  = pos_new;
		if (pos_cl < pos_lo) begin
			pos_cl = pos_lo;
		end
		if (pos_cl > pos_hi) begin
			pos_cl = pos_hi;
		end
	end

	// select multiplier operands for the current step
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_MACC: begin
				mul_a = 24'(accel_q);
				mul_b = 18'(dt_q);
			end
			S_MFL: begin
				mul_a = 24'(lw_q[21] ? -lw_q : lw_q);
				mul_b = 18'(ff_q);
			end
			S_MFR: begin
				mul_a = 24'(rw_q[21] ? -rw_q : rw_q);
				mul_b = 18'(ff_q);
			end
			S_MDIF: begin
				mul_a = 24'(diff_mag);
				mul_b = 18'(dt_q);
			end
			S_MDEN: begin
				mul_a = 24'(tw_eff);
				mul_b = 18'(ddps_pkg::TWO_PI_Q11);
			end
			S_MSUM: begin
				mul_a = 24'(psum_mag);
				mul_b = 18'(dt_q);
			end
			S_TSL, S_TCL: begin
				mul_a = 24'(t16);
				mul_b = pmag_q[17:0];
			end
			S_TSH, S_TCH: begin
				mul_a = 24'(t16);
				mul_b = {1'b0, pmag_q[34:18]};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign div_start = state_q == S_MSUM;
	assign cor_start = state_q == S_HUPD;

	ddps_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	ddps_div #(
		.NUM_W (NUM_W),
		.Q_W   (ACC_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (mul_p[ddps_pkg::DEN_W-1:0]),
		.done     (div_done),
		.quot     (div_quot)
	);

	ddps_cordic #(
		.STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start),
		.angle  (acc_nx[ACC_W-1 -: 16]),
		.done   (cor_done),
		.cos_o  (cos_v),
		.sin_o  (sin_v)
	);

	// take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_q <= 18'd160846;
			lim_q   <= 18'd160846;
			ff_q    <= 16'd63570;
			db_q    <= 16'd256;
			tw_q    <= 20'd25600;
			blo_q   <= 20'd25600;
			bhx_q   <= 20'd204800;
			bhy_q   <= 20'd204800;
		end else if (cfg_we) begin
			case (cfg_index)
				ddps_pkg::REG_ACCEL_RATE:   accel_q <= cfg_data[17:0];
				ddps_pkg::REG_SPEED_LIMIT:  lim_q   <= cfg_data[17:0];
				ddps_pkg::REG_FRICTION:     ff_q    <= cfg_data[15:0];
				ddps_pkg::REG_DEADBAND:     db_q    <= cfg_data[15:0];
				ddps_pkg::REG_TRACK_WIDTH:  tw_q    <= cfg_data;
				ddps_pkg::REG_BOUND_LOW:    blo_q   <= cfg_data;
				ddps_pkg::REG_BOUND_HIGH_X: bhx_q   <= cfg_data;
				ddps_pkg::REG_BOUND_HIGH_Y: bhy_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer, pose state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			l_q         <= '0;
			r_q         <= '0;
			x_q         <= 20'd38400;
			y_q         <= 20'd38400;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: if (accept) state_q <= S_MACC;
				S_MACC: state_q <= S_CMD;
				S_CMD:  state_q <= S_MFL;
				S_MFL:  state_q <= S_MFR;
				S_MFR: begin
					l_q     <= sh_val;
					state_q <= S_RSH;
				end
				S_RSH: begin
					r_q     <= sh_val;
					state_q <= S_MDIF;
				end
				S_MDIF: state_q <= S_MDEN;
				S_MDEN: state_q <= S_MSUM;
				S_MSUM: state_q <= S_WP;
				S_WP:   state_q <= S_DIV;
				S_DIV:  if (div_done) state_q <= S_HUPD;
				S_HUPD: begin
					acc_q   <= acc_nx;
					state_q <= S_CORD;
				end
				S_CORD: if (cor_done) state_q <= S_TSL;
				S_TSL:  state_q <= S_TSH;
				S_TSH:  state_q <= S_TCL;
				S_TCL: begin
					x_q     <= pos_cl[19:0];
					state_q <= S_TCH;
				end
				S_TCH:  state_q <= S_TY;
				S_TY: begin
					y_q     <= pos_cl[19:0];
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// working payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= {right_reverse, left_reverse, spin_negative, spin_positive};
			dt_q  <= time_step;
		end
		if (state_q == S_CMD) begin
			lw_q <= cl;
			rw_q <= cr;
		end
		if (state_q == S_MDIF) begin
			diffneg_q <= diff[19];
		end
		if (state_q == S_MDEN) begin
			prod_q <= mul_p[34:0];
		end
		if (state_q == S_MSUM) begin
			psign_q <= psum[19];
		end
		if (state_q == S_WP) begin
			pmag_q <= mul_p[34:0];
		end
		if (state_q == S_TSH || state_q == S_TCH) begin
			plo_q <= mul_p[35:0];
		end
		if (state_q == S_DONE && out_free) begin
			pos_x       <= x_q;
			pos_y       <= y_q;
			heading     <= acc_q[ACC_W-1 -: 16];
			left_speed  <= l_q;
			right_speed <= r_q;
		end
	end

	assign out_valid = out_valid_q;

	`ASSERT_IMPL(a_ready_idle, clk, arst_n, in_ready, state_q == S_IDLE)
	`ASSERT_IMPL(a_div_done_state, clk, arst_n, div_done, state_q == S_DIV)
	`ASSERT_IMPL(a_cor_done_state, clk, arst_n, cor_done, state_q == S_CORD)
	`ASSERT_NEXT(a_done_loads, clk, arst_n, state_q == S_DONE && !out_valid_q, out_valid_q)

endmodule

[src/ddps_mul.sv]
// Shared unsigned multiplier with a registered product
module ddps_mul (
	input  logic                         clk,
	input  logic [ddps_pkg::MUL_A_W-1:0] a,
	input  logic [ddps_pkg::MUL_B_W-1:0] b,
	output logic [ddps_pkg::MUL_P_W-1:0] p
);

	// register the full product
	always_ff @(posedge clk) begin
		p <= ddps_pkg::MUL_P_W'(a) * ddps_pkg::MUL_P_W'(b);
	end

endmodule

[src/ddps_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle
module ddps_div #(
	parameter int NUM_W = 63,
	parameter int Q_W   = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [NUM_W-1:0]           dividend,
	input  logic [ddps_pkg::DEN_W-1:0] divisor,
	output logic                       done,
	output logic [Q_W-1:0]             quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0]           num_q;
	logic [ddps_pkg::DEN_W-1:0] den_q;
	logic [ddps_pkg::DEN_W-1:0] rem_q;
	logic [Q_W-1:0]             quot_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [ddps_pkg::DEN_W:0]   rem_sh;
	logic [ddps_pkg::DEN_W:0]   rem_sub;
	logic                       ge;

	// trial subtract of the divisor
	always_comb begin
		rem_sh  = {rem_q, num_q[NUM_W-1]};
		ge      = rem_sh >= {1'b0, den_q};
		rem_sub = rem_sh - {1'b0, den_q};
	end

	// control: count the quotient bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: shift in a dividend bit, keep the low quotient bits
	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= dividend;
			den_q  <= divisor;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			num_q  <= {num_q[NUM_W-2:0], 1'b0};
			rem_q  <= ge ? rem_sub[ddps_pkg::DEN_W-1:0] : rem_sh[ddps_pkg::DEN_W-1:0];
			quot_q <= {quot_q[Q_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

[src/ddps_cordic.sv]
// Iterative CORDIC in rotation mode: cosine and sine of a 16-bit angle, Q30
module ddps_cordic #(
	parameter int STEPS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [15:0]                        angle,
	output logic                               done,
	output logic signed [ddps_pkg::TRIG_W-1:0] cos_o,
	output logic signed [ddps_pkg::TRIG_W-1:0] sin_o
);

	localparam int W = ddps_pkg::TRIG_W;

	logic signed [W-1:0] x_q, y_q, z_q;
	logic signed [W-1:0] dx, dy, at;
	logic [4:0]          i_q;
	logic                busy_q, done_q, flip_q;
	logic                flip;
	logic [15:0]         folded;

	// fold into the right half-plane by a half-turn
	always_comb begin
		flip   = angle[15] ^ angle[14];
		folded = {angle[15] ^ flip, angle[14:0]};
		dx     = y_q >>> i_q;
		dy     = x_q >>> i_q;
		at     = $signed({1'b0, ddps_pkg::atan_entry(i_q)});
	end

	// control: count rotations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 1'b1;
				if (i_q == 5'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: one micro-rotation a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= ddps_pkg::CORDIC_GAIN_Q30;
			y_q    <= '0;
			z_q    <= $signed({{(W-32){folded[15]}}, folded, 16'h0});
			flip_q <= flip;
		end else if (busy_q) begin
			if (!z_q[W-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

	assign done  = done_q;
	assign cos_o = flip_q ? -x_q : x_q;
	assign sin_o = flip_q ? -y_q : y_q;

endmodule
